// ----- rtl/gbd_pkg.sv -----
// Package for the Gaussian bunch density pipeline.
// Holds the register index codes, the fixed widths and the exponent table function.
// No dependencies.
`default_nettype none

package gbd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_STAGES  = 9;
   localparam int Y_FRAC_W    = 54;
   localparam int EXP_INT_W   = 9;

   // log2(e) in unsigned Q1.30
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AMPLITUDE = 3'd0,
      CSR_COEF_X    = 3'd1,
      CSR_COEF_Y    = 3'd2,
      CSR_COEF_Z    = 3'd3,
      CSR_OFFSET_X  = 3'd4,
      CSR_OFFSET_Y  = 3'd5,
      CSR_OFFSET_Z  = 3'd6
   } csr_index_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_w;
      rem   = v;
      root  = '0;
      bit_w = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bit_w) begin
            rem  = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // 2^-(idx / 2^bits) in unsigned Q1.32
   function automatic logic [32:0] exp_mantissa(input int bits, input int idx);
      logic [63:0] roots [0:15];
      logic [63:0] mant;
      roots[0] = '0;
      roots[1] = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 2; j < 16; j++) begin
         if (j <= bits) begin
            roots[j] = isqrt64(roots[j-1] << 32);
         end else begin
            roots[j] = '0;
         end
      end
      mant = 64'h1_0000_0000;
      for (int b = 0; b < bits; b++) begin
         if (((idx >> b) & 1) != 0) begin
            mant = (mant * roots[bits-b]) >> 32;
         end
      end
      return mant[32:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gbd_if.sv -----
// Valid/ready channels of the Gaussian bunch density block.
// gbd_req_if carries one particle position, gbd_rsp_if one density result.
// No dependencies.
`default_nettype none

interface gbd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;
   logic signed [31:0] z_pos;
   logic               last_in;

   modport source (output valid, x_pos, y_pos, z_pos, last_in, input ready);
   modport sink   (input valid, x_pos, y_pos, z_pos, last_in, output ready);
endinterface

interface gbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] density_out;
   logic        last_out;

   modport source (output valid, density_out, last_out, input ready);
   modport sink   (input valid, density_out, last_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/gaussian_bunch_density_top.sv -----
// An accepted item passes stages 0 to 8 in order. Throughput: one item per cycle
// while rsp_ch is ready; the quadratic form, exp2 and amplitude multiply
// are split over nine register stages, each with its own valid bit.
// A stalled output holds only the full stages behind it; empty stages keep filling.
// Synchronous reset clears all valid bits and all configuration registers to 0.
// Depends on gbd_pkg and gbd_if.
`default_nettype none

module gaussian_bunch_density_top #(
   parameter int EXP_TABLE_BITS = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [gbd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [gbd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   gbd_req_if.sink                                  req_ch,
   gbd_rsp_if.source                                rsp_ch
);
   import gbd_pkg::*;

   localparam int TABLE_SIZE = 1 << EXP_TABLE_BITS;

   // configuration
   logic [31:0] amplitude_ff;
   logic [31:0] coef_ff   [3];
   logic [31:0] offset_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            coef_ff[a]   <= '0;
            offset_ff[a] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_AMPLITUDE: amplitude_ff <= csr_wdata;
            CSR_COEF_X:    coef_ff[0]   <= csr_wdata;
            CSR_COEF_Y:    coef_ff[1]   <= csr_wdata;
            CSR_COEF_Z:    coef_ff[2]   <= csr_wdata;
            CSR_OFFSET_X:  offset_ff[0] <= csr_wdata;
            CSR_OFFSET_Y:  offset_ff[1] <= csr_wdata;
            CSR_OFFSET_Z:  offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // exponent mantissa table
   logic [32:0] exp_table [TABLE_SIZE];

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_table
      localparam logic [32:0] MANT = gbd_pkg::exp_mantissa(EXP_TABLE_BITS, g);
      assign exp_table[g] = MANT;
   end

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   stage_en;
   logic                  last_ff [NUM_STAGES];

   always_comb begin
      stage_en[NUM_STAGES] = rsp_ch.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_ch.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         last_ff[0] <= req_ch.last_in;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // stage 0: offset and magnitude
   logic [31:0] pos_w [3];
   logic [31:0] mag_in [3];
   logic [31:0] mag_ff [3];

   assign pos_w[0] = req_ch.x_pos;
   assign pos_w[1] = req_ch.y_pos;
   assign pos_w[2] = req_ch.z_pos;

   always_comb begin
      logic [32:0] d;
      logic [32:0] abs_d;
      for (int a = 0; a < 3; a++) begin
         d      = {pos_w[a][31], pos_w[a]} + {offset_ff[a][31], offset_ff[a]};
         abs_d  = d[32] ? (~d + 33'd1) : d;
         mag_in[a] = abs_d[32] ? 32'hFFFF_FFFF : abs_d[31:0];
      end
   end

   // stage 1: square
   logic [63:0] sq_ff [3];
   // stage 2: coefficient products
   logic [63:0] top_ff [3];
   logic [63:0] low_ff [3];
   // stage 3: terms in Q8.24, clamped to 2^32
   logic [32:0] term_in [3];
   logic [32:0] term_ff [3];

   always_comb begin
      logic [40:0] t;
      for (int a = 0; a < 3; a++) begin
         t = 41'({top_ff[a][23:0], 8'b0}) + 41'(low_ff[a][63:24]);
         if (top_ff[a][63:24] != '0 || t[40:32] != '0) begin
            term_in[a] = 33'h1_0000_0000;
         end else begin
            term_in[a] = t[32:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (stage_en[0]) begin
            mag_ff[a] <= mag_in[a];
         end
         if (stage_en[1]) begin
            sq_ff[a] <= 64'(mag_ff[a]) * 64'(mag_ff[a]);
         end
         if (stage_en[2]) begin
            top_ff[a] <= 64'(coef_ff[a]) * 64'(sq_ff[a][63:32]);
            low_ff[a] <= 64'(coef_ff[a]) * 64'(sq_ff[a][31:0]);
         end
         if (stage_en[3]) begin
            term_ff[a] <= term_in[a];
         end
      end
   end

   // stage 4: sum and saturate q
   logic [34:0] q_sum;
   logic [31:0] q_ff;

   assign q_sum = 35'(term_ff[0]) + 35'(term_ff[1]) + 35'(term_ff[2]);

   // stage 5: y = q * log2(e)
   logic [62:0]                y_full;
   logic [EXP_INT_W-1:0]       n_ff;
   logic [EXP_TABLE_BITS-1:0]  idx_ff;

   assign y_full = 63'(q_ff) * 63'(LOG2E_Q30);

   // stage 6: table lookup
   logic [32:0] mant_ff;
   logic [4:0]  shift6_ff;
   logic        under6_ff;
   // stage 7: amplitude product
   logic [63:0] prod_ff;
   logic [4:0]  shift7_ff;
   logic        under7_ff;
   // stage 8: output shift
   logic [63:0] shifted;
   logic [31:0] density_ff;

   assign shifted = prod_ff >> shift7_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         q_ff <= (q_sum[34:32] != '0) ? 32'hFFFF_FFFF : q_sum[31:0];
      end
      if (stage_en[5]) begin
         n_ff   <= y_full[62:Y_FRAC_W];
         idx_ff <= y_full[Y_FRAC_W-1 -: EXP_TABLE_BITS];
      end
      if (stage_en[6]) begin
         mant_ff   <= exp_table[idx_ff];
         shift6_ff <= n_ff[4:0];
         under6_ff <= (n_ff[EXP_INT_W-1:5] != '0);
      end
      if (stage_en[7]) begin
         prod_ff   <= mant_ff[32] ? {amplitude_ff, 32'b0}
                                  : 64'(amplitude_ff) * 64'(mant_ff[31:0]);
         shift7_ff <= shift6_ff;
         under7_ff <= under6_ff;
      end
      if (stage_en[8]) begin
         density_ff <= under7_ff ? '0 : shifted[63:32];
      end
   end

   assign rsp_ch.valid       = valid_ff[NUM_STAGES-1];
   assign rsp_ch.density_out = density_ff;
   assign rsp_ch.last_out    = last_ff[NUM_STAGES-1];

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_ff[0])
      else $error("accepted item missing from first stage");

   a_block_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff) && !rsp_ch.ready)
      else $error("input blocked while pipeline has a bubble");

   a_bubble_fills: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[NUM_STAGES-1] && valid_ff[NUM_STAGES-2] |=> valid_ff[NUM_STAGES-1])
      else $error("item did not advance into empty output stage");
`endif

endmodule

`default_nettype wire

// ----- tb/gbd_density_checker.sv -----
// Checker for the Gaussian bunch density block: watches the CSR port and both channels,
// predicts amplitude*exp(-q) per accepted item and compares results in order.
// Depends on gbd_pkg and gbd_if.
module gbd_density_checker #(
   parameter int TABLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   gbd_req_if                                 req_ch,
   gbd_rsp_if                                 rsp_ch,
   output int                                 mismatches,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import gbd_pkg::*;

   localparam logic [63:0] LOG2E_Q2_30 = 64'd1549082005;
   localparam int          EXP_FRAC_W  = 54;
   localparam int          MAX_REPORTS = 10;

   typedef struct packed {
      logic [31:0] density;
      logic        last;
   } density_type;

   logic [31:0] amp_r, cx_r, cy_r, cz_r, ox_r, oy_r, oz_r;
   logic [63:0] mant_lut [0:(1<<TABLE_BITS)-1];
   density_type density_q [$];
   int          err_count = 0;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [127:0] trial;
      logic [63:0]  r;
      r = '0;
      for (int k = 32; k >= 0; k--) begin
         trial = {64'd0, r | (64'd1 << k)};
         if (trial * trial <= {64'd0, v}) begin
            r = trial[63:0];
         end
      end
      return r;
   endfunction

   // c*d^2 in Q8.24, truncated; 2^32 marks an overflowed term
   function automatic logic [63:0] axis_term(input logic [31:0] c, input logic [31:0] p,
                                             input logic [31:0] o);
      longint      d;
      logic [63:0] mag, sq, hi_prod;
      d = longint'($signed(p)) + longint'($signed(o));
      mag = (d < 0) ? -d : d;
      if (mag > 64'hFFFF_FFFF) begin
         mag = 64'hFFFF_FFFF;
      end
      sq = mag * mag;
      hi_prod = {32'd0, c} * {32'd0, sq[63:32]};
      if (hi_prod >= 64'h0100_0000) begin
         return 64'h1_0000_0000;
      end
      return (hi_prod << 8) + (({32'd0, c} * {32'd0, sq[31:0]}) >> 24);
   endfunction

   function automatic density_type predict_density(input logic [31:0] xp,
                                                   input logic [31:0] yp,
                                                   input logic [31:0] zp, input logic lst);
      logic [63:0] q, y, prod;
      int unsigned n, shift;
      int          idx;
      density_type r;
      q = axis_term(cx_r, xp, ox_r) + axis_term(cy_r, yp, oy_r) + axis_term(cz_r, zp, oz_r);
      if (q > 64'hFFFF_FFFF) begin
         q = 64'hFFFF_FFFF;
      end
      y = q * LOG2E_Q2_30;
      n = 32'(y >> EXP_FRAC_W);
      idx = int'((y >> (EXP_FRAC_W - TABLE_BITS)) & ((64'd1 << TABLE_BITS) - 1));
      prod = {32'd0, amp_r} * mant_lut[idx];
      shift = 32 + n;
      r.density = (shift >= 64) ? 32'd0 : 32'(prod >> shift);
      r.last = lst;
      return r;
   endfunction

   initial begin : build_lut
      logic [63:0] roots [0:TABLE_BITS];
      logic [63:0] m;
      roots[0] = '0;
      roots[1] = floor_sqrt(64'h8000_0000_0000_0000);
      for (int j = 2; j <= TABLE_BITS; j++) begin
         roots[j] = floor_sqrt(roots[j-1] << 32);
      end
      for (int i = 0; i < (1 << TABLE_BITS); i++) begin
         m = 64'h1_0000_0000;
         for (int b = 0; b < TABLE_BITS; b++) begin
            if (((i >> b) & 1) != 0) begin
               m = (m * roots[TABLE_BITS-b]) >> 32;
            end
         end
         mant_lut[i] = m;
      end
   end

   always @(posedge clock) begin : scoreboard
      density_type got, want;
      if (reset) begin
         density_q.delete();
         amp_r = '0;
         cx_r  = '0;
         cy_r  = '0;
         cz_r  = '0;
         ox_r  = '0;
         oy_r  = '0;
         oz_r  = '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            density_q.insert(density_q.size(),
                             predict_density(req_ch.x_pos, req_ch.y_pos, req_ch.z_pos,
                                             req_ch.last_in));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.density = rsp_ch.density_out;
            got.last    = rsp_ch.last_out;
            if (density_q.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected result density %h last %b",
                           $time, got.density, got.last);
               end
            end else begin
               want = density_q.pop_front();
               if (got.density !== want.density || got.last !== want.last) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS) begin
                     $display("%0t: density mismatch: expected %h last %b, got %h last %b",
                              $time, want.density, want.last, got.density, got.last);
                  end
               end
            end
         end
         // the bench must change registers only while idle, not enforced here; predictions above use the old values
         if (csr_we) begin
            case (csr_index)
               CSR_AMPLITUDE: amp_r = csr_wdata;
               CSR_COEF_X:    cx_r  = csr_wdata;
               CSR_COEF_Y:    cy_r  = csr_wdata;
               CSR_COEF_Z:    cz_r  = csr_wdata;
               CSR_OFFSET_X:  ox_r  = csr_wdata;
               CSR_OFFSET_Y:  oy_r  = csr_wdata;
               CSR_OFFSET_Z:  oz_r  = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches <= err_count;
      pending    <= density_q.size();
   end

endmodule

// ----- tb/tb_gaussian_bunch_density_top.sv -----
// Testbench top for gaussian_bunch_density_top: directed and random particle positions
// under several register settings and idle patterns, checked by gbd_density_checker.
// Depends on gbd_pkg, gbd_if, gbd_density_checker and the block itself.
module tb_gaussian_bunch_density_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gbd_pkg::*;

   localparam int TABLE_BITS      = 10;
   localparam int PIPE_LATENCY    = 9;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int RX_HOLD_CYCLES  = 100;
   localparam int STALL_LIMIT     = 2000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [31:0] amplitude;
      logic [31:0] coef_x, coef_y, coef_z;
      logic [31:0] offset_x, offset_y, offset_z;
   } density_cfg_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   rx_hold;
   int                     rx_idle_pct;
   int                     tx_idle_pct;
   int                     mismatches;
   int                     pending;
   int                     idle_cycles;

   gbd_req_if req_ch();
   gbd_rsp_if rsp_ch();

   gaussian_bunch_density_top #(.EXP_TABLE_BITS(TABLE_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   gbd_density_checker #(.TABLE_BITS(TABLE_BITS)) density_chk (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL");
      $finish;
   end

   function automatic density_cfg_type make_cfg(input logic [31:0] amp,
                                                input logic [31:0] cx,
                                                input logic [31:0] cy, input logic [31:0] cz,
                                                input logic [31:0] ox, input logic [31:0] oy,
                                                input logic [31:0] oz);
      density_cfg_type c;
      c.amplitude = amp;
      c.coef_x    = cx;
      c.coef_y    = cy;
      c.coef_z    = cz;
      c.offset_x  = ox;
      c.offset_y  = oy;
      c.offset_z  = oz;
      return c;
   endfunction

   function automatic logic [31:0] rand_coef();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 10) return 32'd0;
      if (sel < 20) return $urandom;
      return $urandom_range(0, 32'h0003_0000);
   endfunction

   function automatic logic [31:0] rand_offset();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 5) return 32'h8000_0000;
      if (sel < 10) return 32'h7FFF_FFFF;
      if (sel < 20) return $urandom;
      return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   function automatic logic [31:0] rand_amplitude();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 5) return 32'd0;
      if (sel < 15) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // mostly near the bunch center so that exp(-q) does not underflow
   function automatic logic [31:0] rand_coord();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      if (sel < 90) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      return $urandom;
   endfunction

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_config(input density_cfg_type c);
      put_reg(CSR_AMPLITUDE, c.amplitude);
      put_reg(CSR_COEF_X, c.coef_x);
      put_reg(CSR_COEF_Y, c.coef_y);
      put_reg(CSR_COEF_Z, c.coef_z);
      put_reg(CSR_OFFSET_X, c.offset_x);
      put_reg(CSR_OFFSET_Y, c.offset_y);
      put_reg(CSR_OFFSET_Z, c.offset_z);
      csr_we <= 1'b0;
   endtask

   task automatic set_idle(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_item(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic lst);
      req_ch.valid   <= 1'b1;
      req_ch.x_pos   <= x;
      req_ch.y_pos   <= y;
      req_ch.z_pos   <= z;
      req_ch.last_in <= lst;
      do @(posedge clock); while (!req_ch.ready);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   initial begin : stimulus
      int phase_i, item_i;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.x_pos   <= '0;
      req_ch.y_pos   <= '0;
      req_ch.z_pos   <= '0;
      req_ch.last_in <= 1'b0;
      rx_hold        <= 1'b0;
      set_idle(30, 56);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit coefficients, full amplitude, centered
      put_reg(CSR_UNUSED, 32'h5A5A_A5A5);
      write_config(make_cfg(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'd0, 32'd0, 32'd0));
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_item(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 1'b0);
      send_item(32'h0002_0000, 32'h0001_0000, 32'hFFFF_8000, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_item(32'h0004_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0004_B000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0000_0100, 32'h0000_0200, 32'hFFFF_FF00, 1'b0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

      // extreme coefficients and offsets, clamped difference on a zero axis
      drain();
      write_config(make_cfg(32'h8000_0001, 32'd0, 32'hFFFF_FFFF, 32'd1,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_item(32'h8000_0000, 32'h8000_0001, 32'h0000_0001, 1'b1);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0000_0000, 32'h8000_0011, 32'h7FFF_FFFF, 1'b0);
      send_item(32'h0000_0000, 32'h8000_0001, 32'h0100_0001, 1'b0);
      send_item(32'h1234_5678, 32'h8000_0101, 32'h0010_0001, 1'b1);
      send_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

      // zero amplitude
      drain();
      write_config(make_cfg(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'd0, 32'd0, 32'd0));
      send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(32'h0000_0100, 32'h0000_0000, 32'h0000_0000, 1'b1);

      // all axes off: q is zero wherever the particle sits
      drain();
      write_config(make_cfg(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
      send_item(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 1'b1);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);

      for (phase_i = 0; phase_i < RANDOM_PHASES; phase_i++) begin
         drain();
         if (phase_i == 3) begin
            set_idle(56, 30);
         end else if (phase_i == 6) begin
            set_idle(0, 0);
         end
         write_config(make_cfg(rand_amplitude(), rand_coef(), rand_coef(), rand_coef(),
                               rand_offset(), rand_offset(), rand_offset()));
         for (item_i = 0; item_i < ITEMS_PER_PHASE; item_i++) begin
            if (phase_i == 6 && item_i == 16) begin
               // output backs up while the sender keeps offering
               fork
                  begin
                     rx_hold <= 1'b1;
                     repeat (RX_HOLD_CYCLES) @(posedge clock);
                     rx_hold <= 1'b0;
                  end
               join_none
            end
            if (phase_i == 4 && item_i == 64) begin
               drain();
            end
            send_item(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
         end
      end

      drain();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gbd_pkg.sv
rtl/gbd_if.sv
rtl/gaussian_bunch_density_top.sv
tb/gbd_density_checker.sv
tb/tb_gaussian_bunch_density_top.sv
